/* src/m3i_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package m3i_pkg;

  localparam int unsigned IN_W     = 16;
  localparam int unsigned INV_W    = 32;
  localparam int unsigned ADJ_W    = 33;
  localparam int unsigned DET_W    = 49;
  localparam int unsigned ND_W     = 48;
  localparam int unsigned NUM_W    = 56;
  localparam int unsigned FRAC_SH  = 24;
  localparam int unsigned QW       = 33;
  localparam int unsigned CMP_W    = ND_W + QW + 1;
  localparam int unsigned N_ELEM   = 9;
  localparam int unsigned Q_DEPTH  = 2;

  typedef struct packed {
    logic [N_ELEM-1:0][ADJ_W-1:0] adj;
    logic [DET_W-1:0]             det;
    logic                         sing;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

/* src/m3i_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module m3i_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic signed [m3i_pkg::IN_W-1:0]   a [m3i_pkg::N_ELEM],
  output logic                                   out_valid,
  output m3i_pkg::item_t                         out_item
);

  localparam int PA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int PC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int PD [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic [3:0] valid_r;

  logic signed [2*m3i_pkg::IN_W-1:0] pp_r [m3i_pkg::N_ELEM];
  logic signed [2*m3i_pkg::IN_W-1:0] pn_r [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::IN_W-1:0]   row1_r [3];
  logic signed [m3i_pkg::ADJ_W-1:0]  adj2_r [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::IN_W-1:0]   row2_r [3];
  logic signed [m3i_pkg::ADJ_W-1:0]  adj3_r [m3i_pkg::N_ELEM];
  logic signed [m3i_pkg::DET_W-1:0]  dt3_r [3];
  m3i_pkg::item_t                    item_r;
  logic signed [m3i_pkg::DET_W-1:0]  det_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      pp_r[i] <= a[PA[i]] * a[PB[i]];
      pn_r[i] <= a[PC[i]] * a[PD[i]];
      adj2_r[i] <= m3i_pkg::ADJ_W'(pp_r[i]) - m3i_pkg::ADJ_W'(pn_r[i]);
      adj3_r[i] <= adj2_r[i];
    end
    for (int j = 0; j < 3; j++) begin
      row1_r[j] <= a[j];
      row2_r[j] <= row1_r[j];
    end
    dt3_r[0] <= row2_r[0] * adj2_r[0];
    dt3_r[1] <= row2_r[1] * adj2_r[3];
    dt3_r[2] <= row2_r[2] * adj2_r[6];
    for (int i = 0; i < 9; i++) begin
      item_r.adj[i] <= adj3_r[i];
    end
    item_r.det  <= det_sum;
    item_r.sing <= (det_sum == '0);
  end

  assign det_sum   = dt3_r[0] + dt3_r[1] + dt3_r[2];
  assign out_valid = valid_r[3];
  assign out_item  = item_r;

endmodule
`default_nettype wire

/* src/m3i_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module m3i_queue #(
  parameter int unsigned DEPTH = m3i_pkg::Q_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire m3i_pkg::item_t push_item,
  input  wire logic           pop,
  output m3i_pkg::item_t      head,
  output m3i_pkg::q_status_t  status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  m3i_pkg::item_t mem_r [DEPTH];
  m3i_pkg::item_t head_r;
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign do_push = push && (count_r != CW'(DEPTH));
  assign do_pop  = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // head word held in a register; a word written to the next head slot is forwarded
  always_ff @(posedge clk) begin
    if (do_push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_item;
    end else begin
      head_r <= mem_r[rd_ptr_nxt];
    end
  end

  assign head         = head_r;
  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);

endmodule
`default_nettype wire

/* src/m3i_div_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
module m3i_div_lane (
  input  wire logic                       clk,
  input  wire logic [m3i_pkg::ADJ_W-1:0]  adj,
  input  wire logic                       det_neg,
  input  wire logic [m3i_pkg::ND_W-1:0]   nd,
  input  wire logic [m3i_pkg::ND_W-1:0]   nd_line [m3i_pkg::QW],
  output logic [m3i_pkg::INV_W-1:0]       quo
);

  localparam int unsigned QW    = m3i_pkg::QW;
  localparam int unsigned NUM_W = m3i_pkg::NUM_W;
  localparam int unsigned CMP_W = m3i_pkg::CMP_W;
  localparam int unsigned INV_W = m3i_pkg::INV_W;

  logic [NUM_W-1:0] rem_r [QW+1];
  logic [QW-1:0]    q_r   [QW+1];
  logic             ovf_r [QW+1];
  logic             neg_r [QW+1];
  logic [INV_W-1:0] quo_r;

  logic [m3i_pkg::ADJ_W-1:0] mag;
  logic [NUM_W-1:0]          num;
  logic [CMP_W-1:0]          top_bound;

  assign mag       = adj[m3i_pkg::ADJ_W-1] ? (~adj + 1'b1) : adj;
  assign num       = {mag[INV_W-1:0], {m3i_pkg::FRAC_SH{1'b0}}};
  assign top_bound = {1'b0, nd, {QW{1'b0}}};

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    q_r[0]   <= '0;
    ovf_r[0] <= CMP_W'(num) >= top_bound;
    neg_r[0] <= adj[m3i_pkg::ADJ_W-1] ^ det_neg;
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [CMP_W-1:0] trial;
    logic             ge;
    assign trial = CMP_W'(nd_line[k]) << (QW - 1 - k);
    assign ge    = CMP_W'(rem_r[k]) >= trial;
    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? (rem_r[k] - trial[NUM_W-1:0]) : rem_r[k];
      q_r[k+1]   <= {q_r[k][QW-2:0], ge};
      ovf_r[k+1] <= ovf_r[k];
      neg_r[k+1] <= neg_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (neg_r[QW]) begin
      if (ovf_r[QW] || (q_r[QW] > QW'(33'h0_8000_0000))) begin
        quo_r <= 32'h8000_0000;
      end else begin
        quo_r <= ~q_r[QW][INV_W-1:0] + 1'b1;
      end
    end else begin
      if (ovf_r[QW] || (q_r[QW] > QW'(33'h0_7FFF_FFFF))) begin
        quo_r <= 32'h7FFF_FFFF;
      end else begin
        quo_r <= q_r[QW][INV_W-1:0];
      end
    end
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

/* src/m3i_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module m3i_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire m3i_pkg::item_t             in_item,
  output logic                            out_valid,
  output logic [m3i_pkg::INV_W-1:0]       inv [m3i_pkg::N_ELEM],
  output logic [m3i_pkg::DET_W-1:0]       det,
  output logic                            sing
);

  localparam int unsigned QW   = m3i_pkg::QW;
  localparam int unsigned LINE = QW + 2;

  logic                         v0_r;
  m3i_pkg::item_t               it_r;
  logic [m3i_pkg::ND_W-1:0]     nd_r;
  logic [m3i_pkg::DET_W-1:0]    det_abs;
  logic [m3i_pkg::ND_W-1:0]     nd_line_r [QW];
  logic [LINE-1:0]              v_line_r;
  logic [m3i_pkg::DET_W-1:0]    det_line_r [LINE];
  logic                         sing_line_r [LINE];
  logic [m3i_pkg::INV_W-1:0]    quo [m3i_pkg::N_ELEM];

  assign det_abs = in_item.det[m3i_pkg::DET_W-1] ? (~in_item.det + 1'b1) : in_item.det;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r     <= 1'b0;
      v_line_r <= '0;
    end else begin
      v0_r     <= in_valid;
      v_line_r <= {v_line_r[LINE-2:0], v0_r};
    end
  end

  always_ff @(posedge clk) begin
    it_r <= in_item;
    nd_r <= det_abs[m3i_pkg::ND_W-1:0];
    nd_line_r[0]   <= nd_r;
    det_line_r[0]  <= it_r.det;
    sing_line_r[0] <= it_r.sing;
    for (int k = 1; k < QW; k++) begin
      nd_line_r[k] <= nd_line_r[k-1];
    end
    for (int k = 1; k < LINE; k++) begin
      det_line_r[k]  <= det_line_r[k-1];
      sing_line_r[k] <= sing_line_r[k-1];
    end
  end

  for (genvar e = 0; e < m3i_pkg::N_ELEM; e++) begin : g_lane
    m3i_div_lane u_lane (
      .clk     (clk),
      .adj     (it_r.adj[e]),
      .det_neg (it_r.det[m3i_pkg::DET_W-1]),
      .nd      (nd_r),
      .nd_line (nd_line_r),
      .quo     (quo[e])
    );
    assign inv[e] = sing_line_r[LINE-1] ? '0 : quo[e];
  end

  assign out_valid = v_line_r[LINE-1];
  assign det       = det_line_r[LINE-1];
  assign sing      = sing_line_r[LINE-1];

endmodule
`default_nettype wire

/* src/matrix3_inverse_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// 3x3 matrix inverse by adjugate. One matrix is taken on every cycle that start is high
// and busy low; its result is shown as a one-cycle out_valid strobe, results in order,
// one matrix per cycle sustained. The result path runs through the four-stage
// cofactor/determinant front, the queue, and the 33-stage restoring divider in each
// of the nine element lanes. The receiver cannot stall: out_valid words must be
// taken when shown. Since the divider takes a word every cycle, busy stays low in use.
module matrix3_inverse_core #(
  parameter int unsigned QUEUE_DEPTH = m3i_pkg::Q_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_a_00,
  input  wire logic [15:0] in_a_01,
  input  wire logic [15:0] in_a_02,
  input  wire logic [15:0] in_a_10,
  input  wire logic [15:0] in_a_11,
  input  wire logic [15:0] in_a_12,
  input  wire logic [15:0] in_a_20,
  input  wire logic [15:0] in_a_21,
  input  wire logic [15:0] in_a_22,
  output logic             out_valid,
  output logic [31:0]      out_inv_00,
  output logic [31:0]      out_inv_01,
  output logic [31:0]      out_inv_02,
  output logic [31:0]      out_inv_10,
  output logic [31:0]      out_inv_11,
  output logic [31:0]      out_inv_12,
  output logic [31:0]      out_inv_20,
  output logic [31:0]      out_inv_21,
  output logic [31:0]      out_inv_22,
  output logic [48:0]      out_determinant,
  output logic             out_singular
);

  logic signed [m3i_pkg::IN_W-1:0] a [m3i_pkg::N_ELEM];
  logic                            accept;
  logic                            f_valid;
  m3i_pkg::item_t                  f_item;
  m3i_pkg::item_t                  q_head;
  m3i_pkg::q_status_t              q_stat;
  logic                            q_pop;
  logic [m3i_pkg::INV_W-1:0]       inv [m3i_pkg::N_ELEM];

  assign a[0] = in_a_00;
  assign a[1] = in_a_01;
  assign a[2] = in_a_02;
  assign a[3] = in_a_10;
  assign a[4] = in_a_11;
  assign a[5] = in_a_12;
  assign a[6] = in_a_20;
  assign a[7] = in_a_21;
  assign a[8] = in_a_22;

  assign busy   = q_stat.full;
  assign accept = start && !busy;
  assign q_pop  = !q_stat.empty;

  m3i_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .a         (a),
    .out_valid (f_valid),
    .out_item  (f_item)
  );

  m3i_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_item (f_item),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_stat)
  );

  m3i_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_pop),
    .in_item   (q_head),
    .out_valid (out_valid),
    .inv       (inv),
    .det       (out_determinant),
    .sing      (out_singular)
  );

  assign out_inv_00 = inv[0];
  assign out_inv_01 = inv[1];
  assign out_inv_02 = inv[2];
  assign out_inv_10 = inv[3];
  assign out_inv_11 = inv[4];
  assign out_inv_12 = inv[5];
  assign out_inv_20 = inv[6];
  assign out_inv_21 = inv[7];
  assign out_inv_22 = inv[8];

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (out_inv_00 == 0 && out_inv_11 == 0 && out_inv_22 == 0
      && out_inv_01 == 0 && out_inv_02 == 0 && out_inv_10 == 0 && out_inv_12 == 0
      && out_inv_20 == 0 && out_inv_21 == 0))
    else $error("singular result with nonzero inverse");

  a_sing_det: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_singular == (out_determinant == '0)))
    else $error("singular flag disagrees with determinant");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid |-> !q_stat.full)
    else $error("queue overrun");

endmodule
`default_nettype wire
